@@ rtl/edmf_pkg.sv @@
package edmf_pkg;

    localparam int CAP_W   = 32;
    localparam int SCALE_W = 16;
    localparam int DIST_W  = 30;
    localparam int HALF_W  = CAP_W - 1;
    localparam int PROD_W  = HALF_W + SCALE_W;
    localparam int FRAC_W  = 16;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd22479;
    localparam logic [DIST_W-1:0]  DIST_MAX    = {DIST_W{1'b1}};

    // one-hot sequencer codes
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_DEL  = 5'b00100,
        S_INS  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    typedef struct packed {
        logic del;
        logic ins;
    } t_cell_ctrl;

endpackage

@@ rtl/echo_distance_median_filter.sv @@
// Echo distance running-median filter for one ultrasonic sensor. Each input
// transfer carries the rising- and falling-edge timer captures of one echo;
// a strictly larger falling capture replaces the held difference, otherwise
// the last one is reused. The difference is halved and scaled by the q0.16
// register (reset 22479, about 0.343), saturated to 30 bits, and pushed into
// a WINDOW-deep window that reset fills with zeros. Each input gives exactly
// one output transfer with the raw distance and the window median (for an
// even WINDOW the floored mean of the two middle values). An item passes
// from input transfer to a loaded output register through one multiply
// stage, then two passes over a sorted chain of cells (remove the oldest
// entry, insert the new one), then the median load. A new input is taken
// once the chain is back at rest, while the previous result may still wait
// in the output register; a stalled result holds the chain in the median
// load until the output register frees up. Write the scale register only
// while idle.
module echo_distance_median_filter #(
    parameter int WINDOW = 5
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [edmf_pkg::SCALE_W-1:0]  i_cfg_wr_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [edmf_pkg::CAP_W-1:0]    i_first_capture,
    input  logic [edmf_pkg::CAP_W-1:0]    i_second_capture,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [edmf_pkg::DIST_W-1:0]   o_raw_distance,
    output logic [edmf_pkg::DIST_W-1:0]   o_median_distance
);
    import edmf_pkg::*;

    localparam int AGE_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int MED_LO = (WINDOW - 1) / 2;
    localparam int MED_HI = WINDOW / 2;

    // control state
    t_state             r_state;
    t_state             n_state;
    logic               r_out_valid;
    logic               n_out_valid;
    logic [SCALE_W-1:0] r_scale;

    // payload
    logic [CAP_W-1:0]   r_held;
    logic [DIST_W-1:0]  r_raw;
    logic [DIST_W-1:0]  r_median;

    logic               in_xfer;
    logic               out_xfer;
    logic               out_free;
    logic [DIST_W-1:0]  new_dist;
    logic [DIST_W:0]    mid_sum;
    t_cell_ctrl         cell_ctrl;

    // chain wiring, one entry per cell
    logic [DIST_W-1:0]  cell_dist  [WINDOW];
    logic [AGE_W-1:0]   cell_age   [WINDOW];
    logic [WINDOW-1:0]  cell_gt;
    logic [WINDOW-1:0]  cell_shift;
    logic [WINDOW-1:0]  cell_old;
    logic [WINDOW-1:0]  pair_ok;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_xfer = r_out_valid && !i_out_stall;
    // output register can take a new result this cycle
    assign out_free = !r_out_valid || !i_out_stall;

    assign o_in_stall        = (r_state != S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_raw_distance    = r_raw;
    assign o_median_distance = r_median;

    assign cell_ctrl.del = (r_state == S_DEL);
    assign cell_ctrl.ins = (r_state == S_INS);

    // scale register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_RESET;
        end else if (i_cfg_wr_en) begin
            r_scale <= i_cfg_wr_data;
        end
    end

    // held difference, only replaced by a forward-going capture pair
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else if (in_xfer && (i_second_capture > i_first_capture)) begin
            r_held <= i_second_capture - i_first_capture;
        end
    end

    // product is registered in the multiply state and stays put until the
    // next item, so the insert pass and the output load both see it
    edmf_scale u_scale (
        .i_clk   (i_clk),
        .i_load  (r_state == S_MUL),
        .i_diff  (r_held),
        .i_scale (r_scale),
        .o_dist  (new_dist)
    );

    // sorted chain: cell 0 holds the smallest value, each cell keeps its age
    for (genvar g = 0; g < WINDOW; g++) begin : g_cell
        logic [DIST_W-1:0] prev_dist;
        logic [AGE_W-1:0]  prev_age;
        logic              prev_gt;
        logic [DIST_W-1:0] next_dist;
        logic [AGE_W-1:0]  next_age;
        logic              shift_in;

        if (g == 0) begin : g_head
            assign prev_dist = cell_dist[g];
            assign prev_age  = cell_age[g];
            assign prev_gt   = 1'b0;
            assign shift_in  = 1'b0;
        end else begin : g_body
            assign prev_dist = cell_dist[g-1];
            assign prev_age  = cell_age[g-1];
            assign prev_gt   = cell_gt[g-1];
            assign shift_in  = cell_shift[g-1];
        end

        if (g == WINDOW - 1) begin : g_tail
            assign next_dist = cell_dist[g];
            assign next_age  = cell_age[g];
            assign pair_ok[g] = 1'b1;
        end else begin : g_link
            assign next_dist = cell_dist[g+1];
            assign next_age  = cell_age[g+1];
            assign pair_ok[g] = (cell_dist[g] <= cell_dist[g+1]);
        end

        assign cell_old[g] = (cell_age[g] == AGE_W'(WINDOW - 1));

        edmf_cell #(
            .AGE_W     (AGE_W),
            .RESET_AGE (g),
            .OLD_AGE   (WINDOW - 1),
            .IS_TAIL   (g == WINDOW - 1)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (cell_ctrl),
            .i_new_dist  (new_dist),
            .i_prev_dist (prev_dist),
            .i_prev_age  (prev_age),
            .i_prev_gt   (prev_gt),
            .i_next_dist (next_dist),
            .i_next_age  (next_age),
            .i_shift     (shift_in),
            .o_dist      (cell_dist[g]),
            .o_age       (cell_age[g]),
            .o_gt        (cell_gt[g]),
            .o_shift     (cell_shift[g])
        );
    end

    // median taps at fixed cells; for an odd window both taps are the same
    assign mid_sum = {1'b0, cell_dist[MED_LO]} + {1'b0, cell_dist[MED_HI]};

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (out_xfer) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: n_state = S_DEL;
            S_DEL: n_state = S_INS;
            S_INS: n_state = S_OUT;
            S_OUT: begin
                if (out_free) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            r_raw    <= new_dist;
            r_median <= mid_sum[DIST_W:1];
        end
    end

    // chain stays sorted between items
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (&pair_ok))
        else $error("distance chain out of order");

    // exactly one oldest entry whenever the chain is at rest
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> $onehot(cell_old))
        else $error("window ages corrupted");

    // a result only appears after the median load
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_OUT))
        else $error("output valid without a finished item");

    // a finished item waits rather than overwriting a stalled result
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_out_valid && i_out_stall) |=> (r_state == S_OUT))
        else $error("result dropped under stall");

endmodule

@@ rtl/edmf_scale.sv @@
module edmf_scale (
    input  logic                          i_clk,
    input  logic                          i_load,
    input  logic [edmf_pkg::CAP_W-1:0]    i_diff,
    input  logic [edmf_pkg::SCALE_W-1:0]  i_scale,
    output logic [edmf_pkg::DIST_W-1:0]   o_dist
);
    import edmf_pkg::*;

    logic [PROD_W-1:0] r_prod;
    logic [PROD_W-1:0] n_prod;
    logic [PROD_W-FRAC_W-1:0] shifted;

    // halve, then scale by the q0.16 factor
    assign n_prod = PROD_W'(i_diff[CAP_W-1:1]) * PROD_W'(i_scale);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= n_prod;
        end
    end

    assign shifted = r_prod[PROD_W-1:FRAC_W];
    assign o_dist  = (shifted > (PROD_W-FRAC_W)'(DIST_MAX)) ? DIST_MAX
                                                            : shifted[DIST_W-1:0];

endmodule

@@ rtl/edmf_cell.sv @@
module edmf_cell #(
    parameter int AGE_W     = 3,
    parameter int RESET_AGE = 0,
    parameter int OLD_AGE   = 4,
    parameter bit IS_TAIL   = 1'b0
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  edmf_pkg::t_cell_ctrl         i_ctrl,
    input  logic [edmf_pkg::DIST_W-1:0]  i_new_dist,
    input  logic [edmf_pkg::DIST_W-1:0]  i_prev_dist,
    input  logic [AGE_W-1:0]             i_prev_age,
    input  logic                         i_prev_gt,
    input  logic [edmf_pkg::DIST_W-1:0]  i_next_dist,
    input  logic [AGE_W-1:0]             i_next_age,
    input  logic                         i_shift,
    output logic [edmf_pkg::DIST_W-1:0]  o_dist,
    output logic [AGE_W-1:0]             o_age,
    output logic                         o_gt,
    output logic                         o_shift
);
    import edmf_pkg::*;

    logic [DIST_W-1:0] r_dist;
    logic [DIST_W-1:0] n_dist;
    logic [AGE_W-1:0]  r_age;
    logic [AGE_W-1:0]  n_age;

    // the oldest entry, or any entry ahead of it, closes the gap
    assign o_shift = i_shift | (r_age == AGE_W'(OLD_AGE));
    // tail cell is the empty slot during insertion
    assign o_gt    = IS_TAIL ? 1'b1 : (r_dist > i_new_dist);
    assign o_dist  = r_dist;
    assign o_age   = r_age;

    always_comb begin
        n_dist = r_dist;
        n_age  = r_age;
        if (i_ctrl.del && o_shift) begin
            n_dist = i_next_dist;
            n_age  = i_next_age;
        end else if (i_ctrl.ins) begin
            if (i_prev_gt) begin
                n_dist = i_prev_dist;
                n_age  = i_prev_age + AGE_W'(1);
            end else if (o_gt) begin
                n_dist = i_new_dist;
                n_age  = '0;
            end else begin
                n_age  = r_age + AGE_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist <= '0;
            r_age  <= AGE_W'(RESET_AGE);
        end else begin
            r_dist <= n_dist;
            r_age  <= n_age;
        end
    end

endmodule
